// File: design/pvd_pkg.sv
package pvd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic signed [32:0] value;
      logic [1:0]         status;
   } rsp_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_TAG = 2'd1;
   localparam logic [1:0] STATUS_TRUNC   = 2'd2;
   localparam logic [1:0] STATUS_END     = 2'd3;

   localparam logic [7:0] NEG_PREFIX   = 8'd255;
   localparam logic [7:0] BAD_LEAD     = 8'd254;
   localparam logic [7:0] MAX_DIRECT   = 8'd250;
   localparam logic [7:0] TAG_ONE_BYTE = 8'd251;
   localparam logic [7:0] TAG_TWO_BYTE = 8'd252;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_NEG     = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        negative_flag;
      logic [2:0]  bytes_remaining;
      logic [1:0]  byte_position;
      logic [31:0] accumulator;
   } dec_state_type;

   localparam dec_state_type IDLE_STATE = '{
      phase:           PH_IDLE,
      negative_flag:   1'b0,
      bytes_remaining: 3'd0,
      byte_position:   2'd0,
      accumulator:     32'd0
   };

endpackage

// File: design/pvd_step.sv
module pvd_step (
   input  pvd_pkg::dec_state_type state,
   input  pvd_pkg::req_type       req,
   output pvd_pkg::dec_state_type next_state,
   output logic                   has_result,
   output pvd_pkg::rsp_type       result
);
   import pvd_pkg::*;

   logic [7:0]  b;
   logic [31:0] acc_merged;
   logic [2:0]  rem_dec;
   logic        lead_neg;

   assign b = req.data_byte;

   // merge the payload byte into its lane
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (state.byte_position == 2'(i)) begin
            acc_merged[8*i +: 8] = state.accumulator[8*i +: 8] | b;
         end else begin
            acc_merged[8*i +: 8] = state.accumulator[8*i +: 8];
         end
      end
   end

   assign rem_dec  = state.bytes_remaining - 3'd1;
   assign lead_neg = (state.phase == PH_NEG);

   always_comb begin
      next_state = state;
      has_result = 1'b0;
      result     = '0;
      case (state.phase)
         PH_PAYLOAD: begin
            if (req.stream_end) begin
               has_result    = 1'b1;
               result.status = STATUS_TRUNC;
               next_state    = IDLE_STATE;
            end else if (rem_dec == 3'd0) begin
               has_result    = 1'b1;
               result.status = STATUS_OK;
               result.value  = state.negative_flag ? {1'b1, ~acc_merged}
                                                   : {1'b0, acc_merged};
               next_state    = IDLE_STATE;
            end else begin
               next_state.accumulator     = acc_merged;
               next_state.byte_position   = state.byte_position + 2'd1;
               next_state.bytes_remaining = rem_dec;
            end
         end
         default: begin
            // idle, post-prefix, and the unused code share the lead-byte path
            next_state = IDLE_STATE;
            if (req.stream_end) begin
               has_result    = 1'b1;
               result.status = lead_neg ? STATUS_TRUNC : STATUS_END;
            end else if (b == NEG_PREFIX && !lead_neg) begin
               next_state.negative_flag = 1'b1;
               next_state.phase         = PH_NEG;
            end else if (b >= BAD_LEAD) begin
               has_result    = 1'b1;
               result.status = STATUS_BAD_TAG;
            end else if (b <= MAX_DIRECT) begin
               has_result    = 1'b1;
               result.status = STATUS_OK;
               result.value  = lead_neg ? {1'b1, 24'hFF_FFFF, ~b}
                                        : {1'b0, 24'd0, b};
            end else begin
               next_state.phase         = PH_PAYLOAD;
               next_state.negative_flag = lead_neg;
               case (b)
                  TAG_ONE_BYTE: next_state.bytes_remaining = 3'd1;
                  TAG_TWO_BYTE: next_state.bytes_remaining = 3'd2;
                  default:      next_state.bytes_remaining = 3'd4;
               endcase
            end
         end
      endcase
   end

endmodule

// File: design/pvd_out_reg.sv
module pvd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  pvd_pkg::rsp_type load_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output pvd_pkg::rsp_type rsp_data,
   output logic             full_stall
);
   import pvd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // hold while stalled, drop once taken, refill on a new result
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_data   = data_ff;
   assign full_stall = valid_ff & rsp_stall;

endmodule

// File: design/prefix_varint_decoder_top.sv
// Decodes a byte stream, one byte per beat, into signed variable-length
// integers (33-bit value plus 2-bit status). One beat is accepted every clock
// while the result register is free or draining; a result appears on rsp_valid
// in the cycle after the beat that completes it. The single result register sets
// the stall: req_stall rises only while a result waits and rsp_stall is high.
module prefix_varint_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pvd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pvd_pkg::rsp_type rsp_data
);
   import pvd_pkg::*;

   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type step_next;
   logic          step_has_result;
   rsp_type       step_result;
   logic          req_accept;
   logic          load;

   pvd_step u_step (
      .state      (state_ff),
      .req        (req_data),
      .next_state (step_next),
      .has_result (step_has_result),
      .result     (step_result)
   );

   assign req_accept = req_valid & ~req_stall;
   assign load       = req_accept & step_has_result;
   assign state_in   = req_accept ? step_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
      end else begin
         state_ff <= state_in;
      end
   end

   pvd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_data  (step_result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .full_stall (req_stall)
   );

`ifndef NO_ASSERTIONS
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.value == 33'sd0))
      else $error("non-ok result carries a nonzero value");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff.phase == PH_IDLE && state_ff.accumulator == 32'd0
                && state_ff.negative_flag == 1'b0))
      else $error("decoder not idle after a result");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_PAYLOAD |-> state_ff.bytes_remaining != 3'd0)
      else $error("payload phase with no bytes remaining");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");
`endif

endmodule
